>>> design/ecr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ecr_pkg;

  localparam int unsigned LETTERS = 26;
  localparam int unsigned LETTER_W = 5;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef struct packed {
    letter_t left;
    letter_t middle;
    letter_t right;
  } rotor_pos_t;

  typedef enum logic [1:0] {
    REG_START_LEFT   = 2'd0,
    REG_START_MIDDLE = 2'd1,
    REG_START_RIGHT  = 2'd2
  } cfg_reg_t;

  localparam letter_t RESET_LEFT   = 5'd2;
  localparam letter_t RESET_MIDDLE = 5'd20;
  localparam letter_t RESET_RIGHT  = 5'd16;

  // rotor and reflector wirings, forward direction
  localparam letter_t WIRE_RIGHT [LETTERS] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
    5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14
  };
  localparam letter_t WIRE_MIDDLE [LETTERS] = '{
    5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
    5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4
  };
  localparam letter_t WIRE_LEFT [LETTERS] = '{
    5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
    5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9
  };
  localparam letter_t WIRE_REFL [LETTERS] = '{
    5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6, 5'd14,
    5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9, 5'd0, 5'd19
  };

  // inverse wirings, return direction
  localparam letter_t INV_RIGHT [LETTERS] = '{
    5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
    5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12
  };
  localparam letter_t INV_MIDDLE [LETTERS] = '{
    5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10, 5'd14,
    5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18
  };
  localparam letter_t INV_LEFT [LETTERS] = '{
    5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4, 5'd2,
    5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9
  };

  function automatic letter_t wrap26(input letter_t v);
    letter_t r;
    r = (v >= 5'(LETTERS)) ? 5'(v - 5'(LETTERS)) : v;
    return r;
  endfunction

  // both operands below 26
  function automatic letter_t add26(input letter_t a, input letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 6'(LETTERS)) ? 5'(s - 6'(LETTERS)) : s[LETTER_W-1:0];
  endfunction

  // both operands below 26
  function automatic letter_t sub26(input letter_t a, input letter_t b);
    logic [LETTER_W:0] t;
    t = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
    return (a >= b) ? 5'(a - b) : t[LETTER_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> design/ecr_stepper.sv
`timescale 1ns / 1ps
`default_nettype none
module ecr_stepper (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic               reload,
  input  wire ecr_pkg::rotor_pos_t start,
  output ecr_pkg::rotor_pos_t     stepped
);
  import ecr_pkg::*;

  rotor_pos_t position;
  rotor_pos_t base;
  rotor_pos_t start_w;

  always_comb begin
    start_w.left   = wrap26(start.left);
    start_w.middle = wrap26(start.middle);
    start_w.right  = wrap26(start.right);
    base = reload ? start_w : position;

    stepped.right  = add26(base.right, 5'd1);
    stepped.middle = base.middle;
    stepped.left   = base.left;
    if (stepped.right == start_w.right) begin
      stepped.middle = add26(base.middle, 5'd1);
      if (stepped.middle == start_w.middle) begin
        stepped.left = add26(base.left, 5'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position.left   <= RESET_LEFT;
      position.middle <= RESET_MIDDLE;
      position.right  <= RESET_RIGHT;
    end else if (advance) begin
      position <= stepped;
    end
  end

endmodule
`default_nettype wire

>>> design/ecr_forward.sv
`timescale 1ns / 1ps
`default_nettype none
module ecr_forward (
  input  wire ecr_pkg::letter_t    letter,
  input  wire ecr_pkg::rotor_pos_t pos,
  output ecr_pkg::letter_t         reflected
);
  import ecr_pkg::*;

  letter_t a;
  letter_t b;
  letter_t c;

  always_comb begin
    a = WIRE_RIGHT[add26(pos.right, wrap26(letter))];
    b = WIRE_MIDDLE[sub26(add26(pos.middle, a), pos.right)];
    c = WIRE_LEFT[sub26(add26(pos.left, b), pos.middle)];
    reflected = WIRE_REFL[sub26(c, pos.left)];
  end

endmodule
`default_nettype wire

>>> design/ecr_reverse.sv
`timescale 1ns / 1ps
`default_nettype none
module ecr_reverse (
  input  wire ecr_pkg::letter_t    reflected,
  input  wire ecr_pkg::rotor_pos_t pos,
  output ecr_pkg::letter_t         letter
);
  import ecr_pkg::*;

  letter_t d;
  letter_t e;

  always_comb begin
    d = sub26(INV_LEFT[add26(reflected, pos.left)], pos.left);
    e = sub26(INV_MIDDLE[add26(d, pos.middle)], pos.middle);
    letter = sub26(INV_RIGHT[add26(e, pos.right)], pos.right);
  end

endmodule
`default_nettype wire

>>> design/enigma_rotor_cipher_core.sv
// channel   dir  signals                            payload
// s_axis    in   tvalid tready tdata[7:0] tuser     letter_in, message_start
// m_axis    out  tvalid tready tdata[7:0]           letter_out
// cfg       in   cfg_we cfg_index[1:0] cfg_data[4:0] start_left/middle/right
//
// One letter per cycle while the output is not stalled; after its transfer a
// letter passes rotor step into stage 1, forward path into stage 2, return
// path into the output register. Rotor positions step at the input transfer.
// Reset restores start registers and rotor positions to 2, 20, 16.
// A stalled output holds each stage that is full; empty stages keep filling.
`timescale 1ns / 1ps
`default_nettype none
module enigma_rotor_cipher_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [4:0] letter_in, [7:5] zero
  input  wire logic       s_axis_tuser,   // [0] message_start
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [4:0] letter_out, [7:5] zero
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [4:0] cfg_data
);
  import ecr_pkg::*;

  rotor_pos_t start;
  rotor_pos_t stepped;

  logic       s1_valid;
  letter_t    s1_letter;
  rotor_pos_t s1_pos;

  logic       s2_valid;
  letter_t    s2_reflected;
  rotor_pos_t s2_pos;

  letter_t    fwd_reflected;
  letter_t    rev_letter;
  letter_t    out_letter;

  logic out_ready;
  logic s2_ready;
  logic in_xfer;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign s2_ready      = !s2_valid || out_ready;
  assign s_axis_tready = !s1_valid || s2_ready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {3'b000, out_letter};

  always_ff @(posedge clk) begin
    if (rst) begin
      start.left   <= RESET_LEFT;
      start.middle <= RESET_MIDDLE;
      start.right  <= RESET_RIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_LEFT:   start.left   <= cfg_data;
        REG_START_MIDDLE: start.middle <= cfg_data;
        REG_START_RIGHT:  start.right  <= cfg_data;
        default:          ;
      endcase
    end
  end

  ecr_stepper u_stepper (
    .clk     (clk),
    .rst     (rst),
    .advance (in_xfer),
    .reload  (s_axis_tuser),
    .start   (start),
    .stepped (stepped)
  );

  ecr_forward u_forward (
    .letter    (s1_letter),
    .pos       (s1_pos),
    .reflected (fwd_reflected)
  );

  ecr_reverse u_reverse (
    .reflected (s2_reflected),
    .pos       (s2_pos),
    .letter    (rev_letter)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        m_axis_tvalid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_letter <= s_axis_tdata[4:0];
      s1_pos    <= stepped;
    end
    if (s2_ready && s1_valid) begin
      s2_reflected <= fwd_reflected;
      s2_pos       <= s1_pos;
    end
    if (out_ready && s2_valid) begin
      out_letter <= rev_letter;
    end
  end

`ifndef SYNTHESIS
  a_out_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_letter < 5'd26))
    else $error("letter_out out of range");

  a_empty_out_accepts: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_pos) && $stable(s1_letter)))
    else $error("stage 1 lost while stalled");

  a_s1_pos_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_pos.left < 5'd26 && s1_pos.middle < 5'd26 && s1_pos.right < 5'd26))
    else $error("rotor position out of range");
`endif

endmodule
`default_nettype wire
